[rtl/kwc_pkg.sv]
// Package for the keyword word counter: sizes, command codes, register map,
// lane control type and character helpers. No dependencies.

package kwc_pkg;

    localparam int NUM_KEYS   = 16;
    localparam int KEY_CHARS  = 16;
    localparam int COUNT_BITS = 32;

    localparam int POS_W  = $clog2(KEY_CHARS + 2);
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_CASE_FOLD = 2'd0;

    typedef enum logic [2:0] {
        CMD_TEXT  = 3'd0,
        CMD_END   = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    typedef struct packed {
        logic             letter;
        logic             close;
        logic             load;
        logic             clear;
        logic             case_fold;
        logic [POS_W-1:0] pos;
        logic [7:0]       text_byte;
        logic [3:0]       load_pos;
        logic [7:0]       load_byte;
    } kwc_ctrl_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cf);
        if (cf && (c >= 8'h41) && (c <= 8'h5A))
            return c + 8'd32;
        return c;
    endfunction

endpackage

[rtl/kwc_in_if.sv]
// Input channel of the keyword word counter: valid/ready handshake with the
// command payload. Depends on nothing.

interface kwc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] byte_value;
    logic [3:0] key_slot;
    logic [3:0] char_position;

    modport source (output valid, command, byte_value, key_slot, char_position,
                    input ready);
    modport sink   (input valid, command, byte_value, key_slot, char_position,
                    output ready);
endinterface

[rtl/kwc_out_if.sv]
// Result channel of the keyword word counter: valid/ready handshake with the
// counter read payload. Depends on nothing.

interface kwc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] count_value;
    logic        count_saturated;

    modport source (output valid, count_value, count_saturated, input ready);
    modport sink   (input valid, count_value, count_saturated, output ready);
endinterface

[rtl/kwc_lane.sv]
// One keyword lane: keyword characters, running match bit and saturating
// occurrence counter. Depends on kwc_pkg.

module kwc_lane
    import kwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kwc_ctrl_t             ctrl,
    input  logic                  sel,
    output logic [COUNT_BITS-1:0] count
);

    logic [7:0]            row_reg [KEY_CHARS];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  match_reg;
    logic                  match_next;
    logic [7:0]            key_char;

    always_comb
    begin
        key_char = 8'd0;
        for (int j = 0; j < KEY_CHARS; j++)
        begin
            if (ctrl.pos == POS_W'(j))
                key_char = row_reg[j];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        match_next = match_reg;
        if (ctrl.letter)
        begin
            if (32'(ctrl.pos) >= KEY_CHARS)
                match_next = 1'b0;
            else if (fold(key_char, ctrl.case_fold) != fold(ctrl.text_byte, ctrl.case_fold))
                match_next = 1'b0;
        end
        if (ctrl.close)
        begin
            if (match_reg && (32'(ctrl.pos) <= KEY_CHARS) && (key_char == 8'd0)
                && !(&count_reg))
                count_next = count_reg + COUNT_BITS'(1);
            match_next = 1'b1;
        end
        if (ctrl.clear)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            match_reg <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < KEY_CHARS; j++)
                row_reg[j] <= 8'd0;
        end
        else if (ctrl.load && sel)
        begin
            for (int j = 0; j < KEY_CHARS; j++)
            begin
                if (32'(ctrl.load_pos) == j)
                    row_reg[j] <= ctrl.load_byte;
            end
        end
    end

    assign count = count_reg;

endmodule

[rtl/keyword_word_counter_top.sv]
// Top level of the keyword word counter: input stage, word tracking, keyword
// lanes, result register and configuration port. Depends on kwc_pkg,
// kwc_in_if, kwc_out_if and kwc_lane.

// The block takes one transaction per clock cycle, whatever the command. A
// transaction is held in an input stage, where every letter is compared with
// the same position of all sixteen keywords at once and a word end updates
// all counters together; a read count result is registered in the output
// register when the read leaves the input stage. Input is stalled only while
// a read result waits in a full output register. The keyword table and
// counters are cleared directly by reset, so the block is ready at once.
// case_fold lies at byte address 0 and resets to 1.

module keyword_word_counter_top
    import kwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    kwc_in_if.sink            text_in,
    kwc_out_if.source         result_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic             case_fold_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    cmd_t             s1_cmd_reg;
    logic [7:0]       s1_byte_reg;
    logic [3:0]       s1_key_reg;
    logic [3:0]       s1_pos_reg;
    logic             s1_adv;
    logic             s1_fire;
    logic             in_fire;
    logic [POS_W-1:0] letter_pos_reg;
    logic [POS_W-1:0] letter_pos_next;
    logic             inside_word_reg;
    logic             inside_word_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_value_reg;
    logic             out_sat_reg;
    kwc_ctrl_t        ctrl;
    logic             is_read;
    logic             do_letter;
    logic             do_close;
    logic [COUNT_BITS-1:0] lane_count [NUM_KEYS];
    logic [COUNT_BITS-1:0] rd_count;
    logic                  rd_hit;
    logic [31:0]           rd_value;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CASE_FOLD) ? DATA_W'(case_fold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            case_fold_reg <= 1'b1;
        else if (psel && penable && pwrite && (paddr == ADDR_CASE_FOLD))
            case_fold_reg <= pwdata[0];
    end

    assign is_read   = (s1_cmd_reg == CMD_READ);
    assign s1_adv    = !is_read || !out_valid_reg || result_out.ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign text_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire   = text_in.valid && text_in.ready;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_adv);

    always_comb
    begin
        do_letter = 1'b0;
        do_close  = 1'b0;
        case (s1_cmd_reg)
            CMD_TEXT:
            begin
                if (is_letter(s1_byte_reg))
                    do_letter = s1_fire;
                else
                    do_close = s1_fire;
            end
            CMD_END:
                do_close = s1_fire;
            default:
            begin
                do_letter = 1'b0;
                do_close  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        letter_pos_next  = letter_pos_reg;
        inside_word_next = inside_word_reg;
        if (do_letter)
        begin
            inside_word_next = 1'b1;
            if (32'(letter_pos_reg) <= KEY_CHARS)
                letter_pos_next = letter_pos_reg + POS_W'(1);
        end
        else if (do_close)
        begin
            inside_word_next = 1'b0;
            letter_pos_next  = '0;
        end
    end

    always_comb
    begin
        ctrl.letter    = do_letter;
        ctrl.close     = do_close && inside_word_reg;
        ctrl.load      = s1_fire && (s1_cmd_reg == CMD_LOAD);
        ctrl.clear     = s1_fire && (s1_cmd_reg == CMD_CLEAR);
        ctrl.case_fold = case_fold_reg;
        ctrl.pos       = letter_pos_reg;
        ctrl.text_byte = s1_byte_reg;
        ctrl.load_pos  = s1_pos_reg;
        ctrl.load_byte = s1_byte_reg;
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kwc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .sel   (32'(s1_key_reg) == k),
            .count (lane_count[k])
        );
    end

    always_comb
    begin
        rd_count = '0;
        rd_hit   = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (32'(s1_key_reg) == k)
            begin
                rd_count = lane_count[k];
                rd_hit   = 1'b1;
            end
        end
    end

    if (COUNT_BITS > 32)
    begin : g_wide
        assign rd_value = (|rd_count[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : rd_count[31:0];
    end
    else
    begin : g_narrow
        assign rd_value = 32'(rd_count);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && is_read)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            letter_pos_reg  <= '0;
            inside_word_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            letter_pos_reg  <= letter_pos_next;
            inside_word_reg <= inside_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg  <= cmd_t'(text_in.command);
            s1_byte_reg <= text_in.byte_value;
            s1_key_reg  <= text_in.key_slot;
            s1_pos_reg  <= text_in.char_position;
        end
        if (s1_fire && is_read)
        begin
            out_value_reg <= rd_hit ? rd_value : 32'd0;
            out_sat_reg   <= rd_hit && (&rd_count);
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.count_value     = out_value_reg;
    assign result_out.count_saturated = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(letter_pos_reg) <= KEY_CHARS + 1)
        else $error("letter position beyond saturation");

    a_pos_outside: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_word_reg |-> (letter_pos_reg == '0))
        else $error("letter position nonzero outside a word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (is_read && out_valid_reg))
        else $error("input stage stalled without a pending read result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && is_read))
        else $error("result raised without a read transaction");
`endif

endmodule
